// File: hdl/svwr_pkg.sv
`timescale 1ns / 1ps
package svwr_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_BITS   = IDX_BITS - 2;
    localparam int QTR_SIZE   = SINE_TABLE_DEPTH / 4;
    localparam int SINE_BITS  = 15;
    localparam int AMP_BITS   = 16;
    localparam int GAIN_BITS  = 17;
    localparam int MAG_BITS   = 32;
    localparam int A4_BITS    = 32;
    localparam int MUL_A_BITS = 32;
    localparam int MUL_B_BITS = 17;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
    localparam int SHIFT_BITS = 5;
    localparam int SEMI_BITS  = 4;

    localparam int OP_BITS      = 2;
    localparam int NOTE_BITS    = 7;
    localparam int VEL_BITS     = 7;
    localparam int S_TDATA_BITS = 16;
    localparam int M_TDATA_BITS = 24;

    localparam logic [A4_BITS-1:0]   A4_RESET  = 32'd42852281;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 17'd65536;
    localparam logic [15:0]          DECAY_Q16 = 16'd64881;
    localparam logic [GAIN_BITS-1:0] STOP_GAIN = 17'd327;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_OFF_TAIL = 2'd2,
        OP_OFF_NOW  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_MAG,
        ST_GAIN,
        ST_DECAY,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_INC,
        CMD_MAG,
        CMD_GAIN,
        CMD_DECAY,
        CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic inc_zero;
        logic releasing;
        logic out_free;
    } dp_status_t;

    localparam logic [MUL_B_BITS-1:0] SEMITONE_Q16 [0:11] = '{
        17'd65536,  17'd69433,  17'd73562,  17'd77936,
        17'd82570,  17'd87480,  17'd92682,  17'd98193,
        17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    typedef logic [SINE_BITS-1:0]             qsine_tab_t [0:QTR_SIZE-1];
    typedef logic [AMP_BITS-1:0]              amp_tab_t   [0:127];
    typedef logic [SHIFT_BITS+SEMI_BITS-1:0]  note_tab_t  [0:127];

    function automatic logic [SINE_BITS-1:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        u2 = (u * u) >> 30;
        t  = 64'd172273;
        t  = 64'd5026995    - ((u2 * t) >> 30);
        t  = 64'd85569306   - ((u2 * t) >> 30);
        t  = 64'd693598668  - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        s  = (u * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_BITS-1:0];
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        for (int i = 0; i < QTR_SIZE; i++) begin
            tab[i] = quarter_sine(64'(i) << (30 - QTR_BITS));
        end
        return tab;
    endfunction

    function automatic amp_tab_t build_amp();
        amp_tab_t tab;
        for (int v = 0; v < 128; v++) begin
            tab[v] = AMP_BITS'((v * 98304 + 635) / 1270);
        end
        return tab;
    endfunction

    // note + 3 split into octave and semitone, octave turned into the right shift
    function automatic note_tab_t build_note();
        note_tab_t tab;
        int        semi;
        int        oct;
        semi = 3;
        oct  = 0;
        for (int k = 0; k < 128; k++) begin
            tab[k] = {SHIFT_BITS'(22 - oct), SEMI_BITS'(semi)};
            if (semi == 11) begin
                semi = 0;
                oct  = oct + 1;
            end else begin
                semi = semi + 1;
            end
        end
        return tab;
    endfunction

    localparam qsine_tab_t           QSINE      = build_qsine();
    localparam logic [SINE_BITS-1:0] QSINE_PEAK = quarter_sine(64'd1 << 30);
    localparam amp_tab_t             AMP_TAB    = build_amp();
    localparam note_tab_t            NOTE_TAB   = build_note();

endpackage

// File: hdl/svwr_ctrl.sv
`timescale 1ns / 1ps
module svwr_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [svwr_pkg::OP_BITS-1:0] s_tuser,
    input  svwr_pkg::dp_status_t       status,
    output svwr_pkg::dp_cmd_t          cmd
);

    svwr_pkg::ctrl_state_t state_reg;
    svwr_pkg::ctrl_state_t state_next;
    svwr_pkg::op_t         op;

    assign op = svwr_pkg::op_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= svwr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            svwr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (op)
                        svwr_pkg::OP_TICK: begin
                            state_next = status.inc_zero ? svwr_pkg::ST_EMIT
                                                         : svwr_pkg::ST_MAG;
                        end
                        svwr_pkg::OP_NOTE_ON: begin
                            state_next = svwr_pkg::ST_INC;
                        end
                        default: begin
                            state_next = svwr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            svwr_pkg::ST_INC: begin
                state_next = svwr_pkg::ST_IDLE;
            end
            svwr_pkg::ST_MAG: begin
                state_next = status.releasing ? svwr_pkg::ST_GAIN : svwr_pkg::ST_EMIT;
            end
            svwr_pkg::ST_GAIN: begin
                state_next = svwr_pkg::ST_DECAY;
            end
            svwr_pkg::ST_DECAY: begin
                state_next = svwr_pkg::ST_EMIT;
            end
            svwr_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = svwr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = svwr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = svwr_pkg::CMD_NONE;
        unique case (state_reg)
            svwr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd      = s_tvalid ? svwr_pkg::CMD_ACCEPT : svwr_pkg::CMD_NONE;
            end
            svwr_pkg::ST_INC:   cmd = svwr_pkg::CMD_INC;
            svwr_pkg::ST_MAG:   cmd = svwr_pkg::CMD_MAG;
            svwr_pkg::ST_GAIN:  cmd = svwr_pkg::CMD_GAIN;
            svwr_pkg::ST_DECAY: cmd = svwr_pkg::CMD_DECAY;
            svwr_pkg::ST_EMIT:  cmd = svwr_pkg::CMD_EMIT;
            default:            cmd = svwr_pkg::CMD_NONE;
        endcase
    end

    a_gain_after_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svwr_pkg::ST_GAIN) |-> ($past(state_reg) == svwr_pkg::ST_MAG))
        else $error("gain step without a preceding level product");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == svwr_pkg::ST_EMIT && !status.out_free)
            |=> (state_reg == svwr_pkg::ST_EMIT))
        else $error("result dropped while output register busy");

endmodule

// File: hdl/svwr_datapath.sv
`timescale 1ns / 1ps
module svwr_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  svwr_pkg::dp_cmd_t                      cmd,
    output svwr_pkg::dp_status_t                   status,
    input  logic [svwr_pkg::S_TDATA_BITS-1:0]      s_tdata,
    input  logic [svwr_pkg::OP_BITS-1:0]           s_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [svwr_pkg::A4_BITS-1:0]           cfg_data,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [svwr_pkg::M_TDATA_BITS-1:0]      m_tdata
);

    localparam int PB   = svwr_pkg::PHASE_BITS;
    localparam int SB   = svwr_pkg::SAMPLE_BITS;
    localparam int MB   = svwr_pkg::MAG_BITS;
    localparam int PBIT = svwr_pkg::MUL_P_BITS;
    localparam int QB   = svwr_pkg::QTR_BITS;
    localparam int PAD  = svwr_pkg::M_TDATA_BITS - SB - 1;
    localparam logic [MB:0] SMP_HALF = (MB + 1)'(1) << (31 - SB);
    localparam logic [MB:0] SMP_MAX  = (MB + 1)'((1 << (SB - 1)) - 1);

    logic [svwr_pkg::A4_BITS-1:0]    a4_reg,     a4_next;
    logic [PB-1:0]                   phase_reg,  phase_next;
    logic [PB-1:0]                   inc_reg,    inc_next;
    logic [svwr_pkg::AMP_BITS-1:0]   amp_reg,    amp_next;
    logic [svwr_pkg::GAIN_BITS-1:0]  gain_reg,   gain_next;
    logic [svwr_pkg::SINE_BITS-1:0]  sin_reg,    sin_next;
    logic                            neg_reg,    neg_next;
    logic [MB-1:0]                   mag_reg,    mag_next;
    logic [svwr_pkg::SEMI_BITS-1:0]  semi_reg,   semi_next;
    logic [svwr_pkg::SHIFT_BITS-1:0] shift_reg,  shift_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [svwr_pkg::M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    svwr_pkg::op_t                   op;
    logic [svwr_pkg::NOTE_BITS-1:0]  note;
    logic [svwr_pkg::VEL_BITS-1:0]   vel;
    logic [svwr_pkg::IDX_BITS-1:0]   idx;
    logic [QB:0]                     qidx;
    logic [svwr_pkg::SHIFT_BITS+svwr_pkg::SEMI_BITS-1:0] note_entry;
    logic [svwr_pkg::MUL_A_BITS-1:0] mul_a;
    logic [svwr_pkg::MUL_B_BITS-1:0] mul_b;
    logic [PBIT-1:0]                 mul_p;
    logic [PBIT:0]                   inc_sum;
    logic [PB-1:0]                   inc_round;
    logic [PBIT-1:0]                 prod_rnd;
    logic [svwr_pkg::GAIN_BITS-1:0]  gain_decayed;
    logic [MB:0]                     smp_sum;
    logic [MB:0]                     smp_full;
    logic [SB-1:0]                   smp_mag;
    logic [SB-1:0]                   sample;
    logic                            active;
    logic                            out_free;

    assign op         = svwr_pkg::op_t'(s_tuser);
    assign note       = s_tdata[svwr_pkg::NOTE_BITS-1:0];
    assign vel        = s_tdata[svwr_pkg::NOTE_BITS +: svwr_pkg::VEL_BITS];
    assign idx        = phase_reg[PB-1 -: svwr_pkg::IDX_BITS];
    assign note_entry = svwr_pkg::NOTE_TAB[note];
    assign out_free   = !m_tvalid_reg || m_tready;
    assign active     = (inc_reg != '0);

    assign status.inc_zero  = (inc_reg == '0);
    assign status.releasing = (gain_reg != '0);
    assign status.out_free  = out_free;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        if (idx[svwr_pkg::IDX_BITS-2]) begin
            qidx = (QB + 1)'(svwr_pkg::QTR_SIZE) - {1'b0, idx[QB-1:0]};
        end else begin
            qidx = {1'b0, idx[QB-1:0]};
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd)
            svwr_pkg::CMD_INC: begin
                mul_a = a4_reg;
                mul_b = svwr_pkg::SEMITONE_Q16[semi_reg];
            end
            svwr_pkg::CMD_MAG: begin
                mul_a = svwr_pkg::MUL_A_BITS'(amp_reg);
                mul_b = svwr_pkg::MUL_B_BITS'(sin_reg);
            end
            svwr_pkg::CMD_GAIN: begin
                mul_a = mag_reg;
                mul_b = gain_reg;
            end
            svwr_pkg::CMD_DECAY: begin
                mul_a = svwr_pkg::MUL_A_BITS'(svwr_pkg::DECAY_Q16);
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p        = PBIT'(mul_a) * PBIT'(mul_b);
    assign inc_sum      = {1'b0, mul_p}
                        + ((PBIT + 1)'(1) << (shift_reg - svwr_pkg::SHIFT_BITS'(1)));
    assign inc_round    = PB'(inc_sum >> shift_reg);
    assign prod_rnd     = mul_p + PBIT'(32768);
    assign gain_decayed = svwr_pkg::GAIN_BITS'(prod_rnd >> 16);

    assign smp_sum  = {1'b0, mag_reg} + SMP_HALF;
    assign smp_full = smp_sum >> (32 - SB);
    assign smp_mag  = (smp_full > SMP_MAX) ? SMP_MAX[SB-1:0] : smp_full[SB-1:0];
    assign sample   = neg_reg ? (SB'(0) - smp_mag) : smp_mag;

    always_comb begin
        a4_next       = cfg_valid ? cfg_data : a4_reg;
        phase_next    = phase_reg;
        inc_next      = inc_reg;
        amp_next      = amp_reg;
        gain_next     = gain_reg;
        sin_next      = sin_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        semi_next     = semi_reg;
        shift_next    = shift_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (cmd)
            svwr_pkg::CMD_ACCEPT: begin
                unique case (op)
                    svwr_pkg::OP_TICK: begin
                        sin_next = qidx[QB] ? svwr_pkg::QSINE_PEAK
                                            : svwr_pkg::QSINE[qidx[QB-1:0]];
                        neg_next = idx[svwr_pkg::IDX_BITS-1];
                        mag_next = '0;
                    end
                    svwr_pkg::OP_NOTE_ON: begin
                        phase_next = '0;
                        amp_next   = svwr_pkg::AMP_TAB[vel];
                        gain_next  = '0;
                        semi_next  = note_entry[svwr_pkg::SEMI_BITS-1:0];
                        shift_next = note_entry[svwr_pkg::SEMI_BITS +: svwr_pkg::SHIFT_BITS];
                    end
                    svwr_pkg::OP_OFF_TAIL: begin
                        if (gain_reg == '0) begin
                            gain_next = svwr_pkg::GAIN_ONE;
                        end
                    end
                    svwr_pkg::OP_OFF_NOW: begin
                        inc_next  = '0;
                        gain_next = '0;
                    end
                    default: begin
                        inc_next = inc_reg;
                    end
                endcase
            end
            svwr_pkg::CMD_INC: begin
                inc_next = inc_round;
            end
            svwr_pkg::CMD_MAG: begin
                mag_next = MB'(mul_p);
            end
            svwr_pkg::CMD_GAIN: begin
                mag_next = MB'(prod_rnd >> 16);
            end
            svwr_pkg::CMD_DECAY: begin
                if (gain_decayed <= svwr_pkg::STOP_GAIN) begin
                    inc_next  = '0;
                    gain_next = '0;
                end else begin
                    gain_next = gain_decayed;
                end
            end
            svwr_pkg::CMD_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD{1'b0}}, active, sample};
                    phase_next    = phase_reg + inc_reg;
                end
            end
            default: begin
                m_tdata_next = m_tdata_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a4_reg       <= svwr_pkg::A4_RESET;
            phase_reg    <= '0;
            inc_reg      <= '0;
            amp_reg      <= '0;
            gain_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            a4_reg       <= a4_next;
            phase_reg    <= phase_next;
            inc_reg      <= inc_next;
            amp_reg      <= amp_next;
            gain_reg     <= gain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sin_reg     <= sin_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        semi_reg    <= semi_next;
        shift_reg   <= shift_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (gain_reg == '0) || (gain_reg > svwr_pkg::STOP_GAIN && gain_reg <= svwr_pkg::GAIN_ONE))
        else $error("release gain outside its live range");

    a_word_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd == svwr_pkg::CMD_EMIT))
        else $error("output word loaded outside emit");

endmodule

// File: hdl/sine_voice_with_release_core.sv
`timescale 1ns / 1ps
// channel   direction  ports                          word
// s_        in         s_tvalid s_tready s_tdata      tuser: operation; tdata: note, velocity
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata      tdata: sample, active
// cfg_      in         cfg_valid cfg_ready cfg_data   a4_increment
//
// Note-off words finish on acceptance; note-on adds the increment step (one shared 32x17 multiplier pass).
// Tick words go straight to emit when silent, through the level product when sounding,
// and also through gain and decay while releasing, all on the one shared multiplier.
// A tick waits in its emit state while the output register is still full.
// aresetn is synchronous: voice silent, release cleared, a4_increment at default.
// cfg_ready is always high; write only while the voice is idle.
module sine_voice_with_release_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [svwr_pkg::S_TDATA_BITS-1:0]    s_tdata,   // note, velocity, zero pad
    input  logic [svwr_pkg::OP_BITS-1:0]         s_tuser,   // operation
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [svwr_pkg::M_TDATA_BITS-1:0]    m_tdata,   // sample, active, zero pad
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [svwr_pkg::A4_BITS-1:0]         cfg_data
);

    svwr_pkg::dp_cmd_t    cmd;
    svwr_pkg::dp_status_t status;

    svwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    svwr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: test/sine_voice_with_release_core_tb.sv
`timescale 1ns / 1ps
module sine_voice_with_release_core_tb;

    localparam int PHASE_ITEMS   = 90;
    localparam int STALL_CYCLES  = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int FULL_TAIL     = 600;

    localparam logic [16:0] REL_START = 17'd65536;
    localparam logic [16:0] REL_FLOOR = 17'd327;
    localparam logic [63:0] REL_DECAY = 64'd64881;

    localparam logic [16:0] SEMI_STEP [0:11] = '{
        17'd65536,  17'd69433,  17'd73562,  17'd77936,
        17'd82570,  17'd87480,  17'd92682,  17'd98193,
        17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    typedef struct packed {
        logic [15:0] smp;
        logic        act;
    } tone_t;

    typedef struct packed {
        svwr_pkg::op_t op;
        logic [6:0]    nt;
        logic [6:0]    vl;
        logic          typed;
        logic [15:0]   smp;
        logic          act;
    } row_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [svwr_pkg::S_TDATA_BITS-1:0] s_tdata   = '0;
    logic [svwr_pkg::OP_BITS-1:0]      s_tuser   = svwr_pkg::OP_TICK;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [svwr_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [svwr_pkg::A4_BITS-1:0]      cfg_data  = '0;

    logic [31:0] a4_inc;
    logic [31:0] osc_phase;
    logic [31:0] osc_inc;
    logic [15:0] level;
    logic [16:0] rel_gain;

    tone_t pending_tones [$];
    int    mismatch_count = 0;
    int    words_sent     = 0;
    int    quiet_cycles   = 0;
    bit    calm           = 1'b0;
    bit    stall_req      = 1'b0;
    bit    long_tail_req  = 1'b0;
    bit    cur_typed      = 1'b0;
    tone_t cur_want       = '0;

    row_t script [0:23] = '{
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{svwr_pkg::OP_OFF_TAIL, 7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{svwr_pkg::OP_OFF_NOW,  7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_NOTE_ON,  7'd0,   7'd127, 1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
        '{svwr_pkg::OP_TICK,     7'd127, 7'd127, 1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_NOTE_ON,  7'd127, 7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
        '{svwr_pkg::OP_NOTE_ON,  7'd69,  7'd127, 1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_OFF_TAIL, 7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_OFF_TAIL, 7'd127, 7'd127, 1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_OFF_NOW,  7'd127, 7'd127, 1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{svwr_pkg::OP_NOTE_ON,  7'd60,  7'd64,  1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{svwr_pkg::OP_TICK,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0}
    };

    sine_voice_with_release_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sin(pi/2 * u), u in Q.30 on [0, 1], result Q0.15
    function automatic logic [14:0] sine_q15(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        if (u > (64'd1 << 30)) begin
            u = 64'd1 << 30;
        end
        u2 = (u * u) >> 30;
        t  = 64'd172273;
        t  = 64'd5026995    - ((u2 * t) >> 30);
        t  = 64'd85569306   - ((u2 * t) >> 30);
        t  = 64'd693598668  - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        s  = (u * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

    function automatic bit voice_step(input svwr_pkg::op_t op, input logic [6:0] nt,
                                      input logic [6:0] vl, output tone_t res);
        int unsigned n;
        int unsigned sh;
        logic [63:0] prod;
        logic [63:0] u;
        logic [63:0] mag;
        logic [63:0] smp;
        logic [9:0]  idx;
        res = '0;
        case (op)
            svwr_pkg::OP_NOTE_ON: begin
                n         = int'(nt) + 3;
                sh        = 22 - n / 12;
                prod      = 64'(a4_inc) * 64'(SEMI_STEP[n % 12]);
                osc_phase = '0;
                level     = 16'((int'(vl) * 98304 + 635) / 1270);
                rel_gain  = '0;
                osc_inc   = 32'((prod + (64'd1 << (sh - 1))) >> sh);
                return 1'b0;
            end
            svwr_pkg::OP_OFF_TAIL: begin
                if (rel_gain == '0) begin
                    rel_gain = REL_START;
                end
                return 1'b0;
            end
            svwr_pkg::OP_OFF_NOW: begin
                osc_inc  = '0;
                rel_gain = '0;
                return 1'b0;
            end
            default: begin
                if (osc_inc == '0) begin
                    return 1'b1;
                end
                idx = osc_phase[31:22];
                u   = 64'(idx[7:0]) << 22;
                if (idx[8]) begin
                    u = (64'd1 << 30) - u;
                end
                mag = 64'(sine_q15(u)) * 64'(level);
                if (rel_gain != '0) begin
                    mag = (mag * 64'(rel_gain) + 64'd32768) >> 16;
                end
                smp = (mag + 64'd32768) >> 16;
                if (smp > 64'd32767) begin
                    smp = 64'd32767;
                end
                res.smp   = idx[9] ? 16'(64'd0 - smp) : smp[15:0];
                osc_phase = osc_phase + osc_inc;
                if (rel_gain != '0) begin
                    rel_gain = 17'((64'(rel_gain) * REL_DECAY + 64'd32768) >> 16);
                    if (rel_gain <= REL_FLOOR) begin
                        osc_inc  = '0;
                        rel_gain = '0;
                    end
                end
                res.act = (osc_inc != '0);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        tone_t res;
        tone_t want;
        if (!aresetn) begin
            a4_inc    = svwr_pkg::A4_RESET;
            osc_phase = '0;
            osc_inc   = '0;
            level     = '0;
            rel_gain  = '0;
        end else begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                a4_inc       = cfg_data;
                quiet_cycles = 0;
            end
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                if (voice_step(svwr_pkg::op_t'(s_tuser), s_tdata[6:0], s_tdata[13:7],
                               res)) begin
                    pending_tones.push_back(cur_typed ? cur_want : res);
                end
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (pending_tones.size() == 0) begin
                    flag_mismatch("word with nothing pending", 32'(m_tdata), 32'd0);
                end else begin
                    want = pending_tones.pop_front();
                    if (m_tdata[15:0] !== want.smp) begin
                        flag_mismatch("sample", 32'(m_tdata[15:0]), 32'(want.smp));
                    end
                    if (m_tdata[16] !== want.act) begin
                        flag_mismatch("active", 32'(m_tdata[16]), 32'(want.act));
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("sine_voice_with_release_core_tb: done, errors");
                $finish;
            end
        end
    end

    always begin
        @(negedge aclk);
        if (stall_req) begin
            m_tready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge aclk);
            stall_req = 1'b0;
        end
        m_tready <= calm || ($urandom_range(99) >= 32);
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input svwr_pkg::op_t op, input logic [6:0] nt,
                             input logic [6:0] vl,
                             input bit typed = 1'b0, input tone_t want = '0);
        while (!calm && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= {2'b00, vl, nt};
        cur_typed = typed;
        cur_want  = want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_word(svwr_pkg::OP_TICK, 7'($urandom_range(127)), 7'($urandom_range(127)));
    endtask

    task automatic play_phrase();
        int          ticks;
        logic [6:0]  nt;
        logic [6:0]  vl;
        int unsigned pick;
        pick = long_tail_req ? 1 : $urandom_range(9);
        if (pick == 0) begin
            repeat ($urandom_range(1, 6)) begin
                send_word(svwr_pkg::op_t'($urandom_range(3)), 7'($urandom_range(127)),
                          7'($urandom_range(127)));
            end
            return;
        end
        case ($urandom_range(11))
            0:       nt = 7'd0;
            1:       nt = 7'd127;
            2:       nt = 7'd117;
            3:       nt = 7'd69;
            default: nt = 7'($urandom_range(127));
        endcase
        case ($urandom_range(9))
            0:       vl = 7'd0;
            1:       vl = 7'd127;
            default: vl = 7'($urandom_range(127));
        endcase
        send_word(svwr_pkg::OP_NOTE_ON, nt, vl);
        repeat ($urandom_range(1, 30)) send_tick();
        pick = long_tail_req ? 0 : $urandom_range(9);
        if (pick <= 5) begin
            send_word(svwr_pkg::OP_OFF_TAIL, 7'($urandom_range(127)),
                      7'($urandom_range(127)));
            if ($urandom_range(3) == 0) begin
                send_word(svwr_pkg::OP_OFF_TAIL, 7'($urandom_range(127)),
                          7'($urandom_range(127)));
            end
            ticks = (long_tail_req || $urandom_range(23) == 0) ? FULL_TAIL
                                                               : $urandom_range(60);
            long_tail_req = 1'b0;
            repeat (ticks) send_tick();
        end else if (pick <= 7) begin
            send_word(svwr_pkg::OP_OFF_NOW, 7'($urandom_range(127)),
                      7'($urandom_range(127)));
            repeat ($urandom_range(0, 4)) send_tick();
        end
    endtask

    task automatic drain_voice();
        s_tvalid <= 1'b0;
        while (pending_tones.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_a4(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] a4_plan [0:5];
        int          start;
        a4_plan = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0000,
                    $urandom, $urandom >> 8, svwr_pkg::A4_RESET};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            send_word(script[i].op, script[i].nt, script[i].vl, script[i].typed,
                      '{script[i].smp, script[i].act});
        end

        for (int ph = 0; ph <= 6; ph++) begin
            if (ph > 0) begin
                drain_voice();
                write_a4(a4_plan[ph-1]);
            end
            calm          = (ph == 4);
            stall_req     = (ph == 1 || ph == 5);
            long_tail_req = (ph == 0);
            start         = words_sent;
            while (words_sent - start < PHASE_ITEMS) play_phrase();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_tones.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("sine_voice_with_release_core_tb: done, clean");
        end else begin
            $display("sine_voice_with_release_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/svwr_pkg.sv
hdl/svwr_ctrl.sv
hdl/svwr_datapath.sv
hdl/sine_voice_with_release_core.sv
test/sine_voice_with_release_core_tb.sv
